/* hw/rtl/iidl_pkg.sv */
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared constants and controller/datapath interface types for the indexed
// insert/delete list.
// ----------------------------------------------------------------------------
package iidl_pkg;

	localparam int DEF_CAPACITY = 128;

	localparam int OPC_W  = 2;
	localparam int POS_W  = 8;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 8;

	typedef logic [OPC_W-1:0]  opc_t;
	typedef logic [STAT_W-1:0] stat_code_t;

	localparam opc_t OP_READ   = 2'd0;
	localparam opc_t OP_INSERT = 2'd1;
	localparam opc_t OP_REMOVE = 2'd2;
	localparam opc_t OP_CLEAR  = 2'd3;

	localparam stat_code_t ST_OK    = 2'd0;
	localparam stat_code_t ST_RANGE = 2'd1;
	localparam stat_code_t ST_FULL  = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture item, check range
		logic move;    // shift one entry per cycle
		logic rd_pos;  // read entry at position
		logic put;     // write inserted value, update count
		logic fetch;   // read first and last entries
		logic resp;    // load result registers
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic ok;
		opc_t op;
		logic move_done;
	} stat_t;

endpackage

/* hw/rtl/indexed_insert_delete_list_core.sv */
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core
// Ordered list of signed 32-bit values in a RAM: read, insert at index,
// remove at index, clear. One result per command.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   command  | start / busy        | opcode, position, value
//   result   | done (1-cycle pulse)| status, read_value, count, is_empty,
//            |                     | first_value, last_value
//
// One command at a time. After the accept edge the controller runs DECIDE,
// then MOVE for a good insert or remove, which moves entries one per cycle
// through the RAM write port, or RDPOS for a good read; clear and rejected
// commands skip both. PUT, FETCH and RESP follow, and done is registered
// from RESP. busy is high from the cycle after accept through the cycle
// before done; the next item can go in at the end of the done cycle. Reset
// empties the list; no clearing pass. The receiver cannot stall done.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_core #(
	parameter int CAPACITY = iidl_pkg::DEF_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [iidl_pkg::OPC_W-1:0]          opcode,
	input  logic [iidl_pkg::POS_W-1:0]          position,
	input  logic signed [iidl_pkg::DATA_W-1:0]  value,
	output logic                                done,
	output logic [iidl_pkg::STAT_W-1:0]         status,
	output logic signed [iidl_pkg::DATA_W-1:0]  read_value,
	output logic [iidl_pkg::CNT_W-1:0]          count,
	output logic                                is_empty,
	output logic signed [iidl_pkg::DATA_W-1:0]  first_value,
	output logic signed [iidl_pkg::DATA_W-1:0]  last_value
);

	iidl_pkg::cmd_t  cmd;
	iidl_pkg::stat_t stat;

	iidl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	iidl_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.position    (position),
		.value       (value),
		.done        (done),
		.status      (status),
		.read_value  (read_value),
		.count       (count),
		.is_empty    (is_empty),
		.first_value (first_value),
		.last_value  (last_value)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in progress");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_empty_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && is_empty) |-> (first_value == '0 && last_value == '0))
		else $error("empty list reports nonzero first or last");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == iidl_pkg::ST_OK || status == iidl_pkg::ST_RANGE ||
		          status == iidl_pkg::ST_FULL))
		else $error("undefined status code");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == iidl_pkg::ST_FULL) |->
			(count == iidl_pkg::CNT_W'(CAPACITY) && !is_empty))
		else $error("full status with list not full");

endmodule

/* hw/rtl/iidl_ram.sv */
// ----------------------------------------------------------------------------
// iidl_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module iidl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

/* hw/rtl/iidl_ctrl.sv */
// ----------------------------------------------------------------------------
// iidl_ctrl
// Command sequencer for the list: decide, shift or read, write, fetch, respond.
// ----------------------------------------------------------------------------
module iidl_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  iidl_pkg::stat_t  stat,
	output iidl_pkg::cmd_t   cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_MOVE   = 3'd2;
	localparam logic [2:0] S_RDPOS  = 3'd3;
	localparam logic [2:0] S_PUT    = 3'd4;
	localparam logic [2:0] S_FETCH  = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (stat.ok && (stat.op == iidl_pkg::OP_INSERT ||
				                         stat.op == iidl_pkg::OP_REMOVE)) begin
					state_d = S_MOVE;
				end else if (stat.ok && stat.op == iidl_pkg::OP_READ) begin
					state_d = S_RDPOS;
				end else begin
					state_d = S_PUT;
				end
			end
			S_MOVE: begin
				cmd.move = 1'b1;
				if (stat.move_done) begin
					state_d = S_PUT;
				end
			end
			S_RDPOS: begin
				cmd.rd_pos = 1'b1;
				state_d    = S_PUT;
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_RESP;
			end
			S_RESP: begin
				cmd.resp = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hw/rtl/iidl_dp.sv */
// ----------------------------------------------------------------------------
// iidl_dp
// List datapath: entry store, count, shift pointers and result registers.
// ----------------------------------------------------------------------------
module iidl_dp #(
	parameter int CAPACITY = iidl_pkg::DEF_CAPACITY
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  iidl_pkg::cmd_t                      cmd,
	output iidl_pkg::stat_t                     stat,
	input  logic [iidl_pkg::OPC_W-1:0]          opcode,
	input  logic [iidl_pkg::POS_W-1:0]          position,
	input  logic signed [iidl_pkg::DATA_W-1:0]  value,
	output logic                                done,
	output logic [iidl_pkg::STAT_W-1:0]         status,
	output logic signed [iidl_pkg::DATA_W-1:0]  read_value,
	output logic [iidl_pkg::CNT_W-1:0]          count,
	output logic                                is_empty,
	output logic signed [iidl_pkg::DATA_W-1:0]  first_value,
	output logic signed [iidl_pkg::DATA_W-1:0]  last_value
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > iidl_pkg::POS_W) ? CW : iidl_pkg::POS_W;

	// control state
	logic [CW-1:0] count_q;
	logic [CW-1:0] left_q;
	logic          pend_q;
	logic          done_q;

	// item and shift payload
	iidl_pkg::opc_t                  op_q;
	iidl_pkg::stat_code_t            st_q;
	logic [AW-1:0]                   pos_q;
	logic [iidl_pkg::DATA_W-1:0]     val_q;
	logic [AW-1:0]                   ptr_q;
	logic [AW-1:0]                   dst_q;
	logic [iidl_pkg::DATA_W-1:0]     rd_q;

	// result registers
	iidl_pkg::stat_code_t            status_q;
	logic [iidl_pkg::DATA_W-1:0]     read_value_q;
	logic [iidl_pkg::CNT_W-1:0]      count_out_q;
	logic                            is_empty_q;
	logic [iidl_pkg::DATA_W-1:0]     first_q;
	logic [iidl_pkg::DATA_W-1:0]     last_q;

	// item decode
	logic [PW-1:0]                   pos_w;
	logic [PW-1:0]                   cnt_w;
	logic [CW-1:0]                   cnt_m1;
	iidl_pkg::stat_code_t            st_d;
	logic [AW-1:0]                   ptr_d;
	logic [CW-1:0]                   left_d;
	logic                            ins_ok;
	logic                            empty;

	// store ports
	logic                            we;
	logic [AW-1:0]                   waddr;
	logic [iidl_pkg::DATA_W-1:0]     wdata;
	logic [AW-1:0]                   raddr_a;
	logic [AW-1:0]                   raddr_b;
	logic [iidl_pkg::DATA_W-1:0]     rdata_a;
	logic [iidl_pkg::DATA_W-1:0]     rdata_b;

	assign pos_w  = PW'(position);
	assign cnt_w  = PW'(count_q);
	assign cnt_m1 = count_q - CW'(1);
	assign empty  = (count_q == '0);
	assign ins_ok = (op_q == iidl_pkg::OP_INSERT) && (st_q == iidl_pkg::ST_OK);

	always_comb begin
		st_d   = iidl_pkg::ST_OK;
		ptr_d  = '0;
		left_d = '0;
		unique case (opcode)
			iidl_pkg::OP_INSERT: begin
				priority if (pos_w > cnt_w) begin
					st_d = iidl_pkg::ST_RANGE;
				end else if (cnt_w >= PW'(CAPACITY)) begin
					st_d = iidl_pkg::ST_FULL;
				end else begin
					ptr_d  = cnt_m1[AW-1:0];
					left_d = count_q - pos_w[CW-1:0];
				end
			end
			iidl_pkg::OP_REMOVE: begin
				if (pos_w >= cnt_w) begin
					st_d = iidl_pkg::ST_RANGE;
				end else begin
					ptr_d  = pos_w[AW-1:0] + AW'(1);
					left_d = cnt_m1 - pos_w[CW-1:0];
				end
			end
			iidl_pkg::OP_READ: begin
				if (pos_w >= cnt_w) begin
					st_d = iidl_pkg::ST_RANGE;
				end
			end
			iidl_pkg::OP_CLEAR: begin
				st_d = iidl_pkg::ST_OK;
			end
			default: begin
				st_d = iidl_pkg::ST_OK;
			end
		endcase
	end

	assign stat.ok        = (st_q == iidl_pkg::ST_OK);
	assign stat.op        = op_q;
	assign stat.move_done = (left_q == '0) && !pend_q;

	// shift pipeline: read one entry, write it one slot over next cycle
	assign we      = (cmd.move && pend_q) || (cmd.put && ins_ok);
	assign waddr   = cmd.put ? pos_q : dst_q;
	assign wdata   = cmd.put ? val_q : rdata_a;
	assign raddr_a = cmd.rd_pos ? pos_q : (cmd.fetch ? '0 : ptr_q);
	assign raddr_b = cnt_m1[AW-1:0];

	iidl_ram #(
		.WIDTH(iidl_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			left_q  <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.resp;
			if (cmd.load) begin
				left_q <= left_d;
				pend_q <= 1'b0;
			end else if (cmd.move) begin
				if (left_q != '0) begin
					left_q <= left_q - CW'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
			end
			if (cmd.put && st_q == iidl_pkg::ST_OK) begin
				unique case (op_q)
					iidl_pkg::OP_INSERT: count_q <= count_q + CW'(1);
					iidl_pkg::OP_REMOVE: count_q <= cnt_m1;
					iidl_pkg::OP_CLEAR:  count_q <= '0;
					iidl_pkg::OP_READ:   count_q <= count_q;
					default:             count_q <= count_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			st_q  <= st_d;
			pos_q <= pos_w[AW-1:0];
			val_q <= value;
			ptr_q <= ptr_d;
		end else if (cmd.move && left_q != '0) begin
			if (op_q == iidl_pkg::OP_INSERT) begin
				ptr_q <= ptr_q - AW'(1);
				dst_q <= ptr_q + AW'(1);
			end else begin
				ptr_q <= ptr_q + AW'(1);
				dst_q <= ptr_q - AW'(1);
			end
		end
		if (cmd.put) begin
			rd_q <= (op_q == iidl_pkg::OP_READ && st_q == iidl_pkg::ST_OK) ? rdata_a : '0;
		end
		if (cmd.resp) begin
			status_q     <= st_q;
			read_value_q <= rd_q;
			count_out_q  <= iidl_pkg::CNT_W'(count_q);
			is_empty_q   <= empty;
			first_q      <= empty ? '0 : rdata_a;
			last_q       <= empty ? '0 : rdata_b;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign count       = count_out_q;
	assign is_empty    = is_empty_q;
	assign first_value = first_q;
	assign last_value  = last_q;

endmodule
